FILE: src/alb_pkg.sv
// Shared types and constants for the LED bar meter.
// Command and status structs between controller and datapath, config indexes,
// color wheel offset table. No dependencies.
`timescale 1ns / 1ps

package alb_pkg;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int INDEX_W   = 6;
    localparam int COLOR_W   = 8;
    localparam int BAR_W     = 7;
    localparam int QUOT_W    = 7;
    localparam int GAIN_W    = 6;
    localparam int LEVEL_W   = QUOT_W + GAIN_W;
    localparam int PROD_W    = 16;
    localparam int SPEED_W   = 8;
    localparam int PERIOD_W  = 16;
    localparam int DECAY_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Full-scale converter reading used by the level scaling
    localparam int FullScale = 1023;
    localparam int WheelDiv  = 50;
    localparam int MaxLeds   = 64;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHEEL_STEP   = 2'd0,
        CFG_GAIN         = 2'd1,
        CFG_DECAY_PERIOD = 2'd2
    } cfg_index_t;

    // Reset values of registers and state
    localparam logic [SPEED_W-1:0]  SPEED_RST  = 8'd3;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 6'd4;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd5;
    localparam logic [BAR_W-1:0]    BAR_RST    = 7'd30;
    localparam logic [COLOR_W-1:0]  WHEEL_RST  = 8'd255;

    // Controller to datapath commands
    typedef struct packed {
        logic load_sample;   // capture sample and its scaled product
        logic calc_quot;     // divide product by full scale
        logic calc_level;    // multiply quotient by gain
        logic update_bar;    // peak-hold update, preset LED counter
        logic emit;          // load one LED color into the output register
        logic finish;        // step wheel and decay counter, bar decay
    } alb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic idx_zero;      // LED counter at index 0
        logic out_free;      // output register can take a new transfer
    } alb_status_t;

    typedef logic [COLOR_W-1:0] wheel_ofs_t [MaxLeds];

    // Wheel offset per LED: floor(i*256/50) mod 256, built at elaboration
    function automatic wheel_ofs_t build_wheel_ofs();
        wheel_ofs_t t;
        for (int k = 0; k < MaxLeds; k++) begin
            t[k] = COLOR_W'((k * 256) / WheelDiv);
        end
        return t;
    endfunction

    localparam wheel_ofs_t WHEEL_OFS = build_wheel_ofs();

endpackage

FILE: src/alb_ctrl.sv
// Sequencing state machine for the LED bar meter.
// Drives the datapath through alb_cmd_t and watches alb_status_t; uses alb_pkg.
`timescale 1ns / 1ps

module alb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  alb_pkg::alb_status_t status,
    output alb_pkg::alb_cmd_t    cmd
);
    import alb_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_QUOT   = 6'b000010,
        S_LEVEL  = 6'b000100,
        S_UPDATE = 6'b001000,
        S_EMIT   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands; refuse samples while reset is held
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_QUOT;
                end
            end
            S_QUOT: begin
                cmd.calc_quot = 1'b1;
                state_next    = S_LEVEL;
            end
            S_LEVEL: begin
                cmd.calc_level = 1'b1;
                state_next     = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.update_bar = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT: begin
                // one LED per free output slot, highest index first
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.idx_zero) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/alb_datapath.sv
// Datapath of the LED bar meter: config registers, level scaling, bar and
// wheel state, LED counter, rainbow color and output register. Uses alb_pkg.
`timescale 1ns / 1ps

module alb_datapath #(
    parameter int LED_COUNT = 60
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [alb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [alb_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic [alb_pkg::SAMPLE_W-1:0]    audio_sample,
    input  alb_pkg::alb_cmd_t               cmd,
    output alb_pkg::alb_status_t            status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [alb_pkg::INDEX_W-1:0]     led_index,
    output logic [alb_pkg::COLOR_W-1:0]     red,
    output logic [alb_pkg::COLOR_W-1:0]     green,
    output logic [alb_pkg::COLOR_W-1:0]     blue,
    output logic                            last
);
    import alb_pkg::*;

    localparam logic [PROD_W-1:0]  LedMul   = PROD_W'(LED_COUNT);
    localparam logic [LEVEL_W-1:0] LevelMax = LEVEL_W'(LED_COUNT);
    localparam logic [INDEX_W-1:0] IdxTop   = INDEX_W'(LED_COUNT - 1);

    logic [SPEED_W-1:0]  speed_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [PERIOD_W-1:0] period_reg;

    logic                nonzero_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [LEVEL_W-1:0]  level_reg;
    logic [BAR_W-1:0]    bar_reg, bar_next;
    logic [COLOR_W-1:0]  wheel_reg, wheel_next;
    logic [DECAY_W-1:0]  decay_reg, decay_next;
    logic [INDEX_W-1:0]  idx_reg;

    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_idx_reg;
    logic [COLOR_W-1:0]  out_r_reg, out_g_reg, out_b_reg;
    logic                out_last_reg;

    // Config writes; unknown index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg  <= SPEED_RST;
            gain_reg   <= GAIN_RST;
            period_reg <= PERIOD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WHEEL_STEP:   speed_reg  <= cfg_data[SPEED_W-1:0];
                CFG_GAIN:         gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_DECAY_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Divide product by 1023: q0 = x>>10, remainder (x mod 1024) + q0 stays
    // below twice the divisor, so one compare corrects it
    logic [PROD_W-11:0]      q0;
    logic [SAMPLE_W:0]       rem;
    always_comb begin
        q0        = prod_reg[PROD_W-1:10];
        rem       = {1'b0, prod_reg[9:0]} + (SAMPLE_W+1)'(q0);
        quot_next = QUOT_W'(q0) + QUOT_W'(rem >= (SAMPLE_W+1)'(FullScale));
    end

    // Peak hold: rise only to an in-range higher level; fall by one on decay
    always_comb begin
        bar_next = bar_reg;
        if (cmd.update_bar) begin
            if (nonzero_reg && (level_reg > LEVEL_W'(bar_reg))
                    && (level_reg <= LevelMax)) begin
                bar_next = level_reg[BAR_W-1:0];
            end
        end else if (cmd.finish) begin
            if (decay_next > DECAY_W'(period_reg) && bar_reg != '0) begin
                bar_next = bar_reg - 1'b1;
            end
        end
    end

    // Wheel step with clamp to 255 on underflow, decay counter advance
    always_comb begin
        if (wheel_reg < speed_reg) begin
            wheel_next = '1;
        end else begin
            wheel_next = wheel_reg - speed_reg;
        end
        decay_next = decay_reg + 1'b1;
    end

    // Level pipeline and per-item state
    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            nonzero_reg <= (audio_sample != '0);
            prod_reg    <= PROD_W'(LedMul * PROD_W'(audio_sample));
        end
        if (cmd.calc_quot) begin
            quot_reg <= quot_next;
        end
        if (cmd.calc_level) begin
            level_reg <= LEVEL_W'(quot_reg * LEVEL_W'(gain_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_reg   <= BAR_RST;
            wheel_reg <= WHEEL_RST;
            decay_reg <= '0;
            idx_reg   <= '0;
        end else begin
            bar_reg <= bar_next;
            if (cmd.finish) begin
                wheel_reg <= wheel_next;
                decay_reg <= (decay_next > DECAY_W'(period_reg)) ? '0 : decay_next;
            end
            if (cmd.update_bar) begin
                idx_reg <= IdxTop;
            end else if (cmd.emit) begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    // Rainbow color of the current LED, black above the bar
    logic [COLOR_W-1:0]  pos;
    logic [COLOR_W-1:0]  ramp;
    logic [COLOR_W-1:0]  col_r, col_g, col_b;
    logic                lit;
    always_comb begin
        pos   = WHEEL_OFS[idx_reg] + wheel_reg;
        lit   = ({1'b0, idx_reg} < bar_reg);
        col_r = '0;
        col_g = '0;
        col_b = '0;
        if (pos < 8'd85) begin
            ramp  = (pos << 1) + pos;
            col_r = ramp;
            col_b = 8'd255 - ramp;
        end else if (pos < 8'd170) begin
            ramp  = ((pos - 8'd85) << 1) + (pos - 8'd85);
            col_g = ramp;
            col_r = 8'd255 - ramp;
        end else begin
            ramp  = ((pos - 8'd170) << 1) + (pos - 8'd170);
            col_b = ramp;
            col_g = 8'd255 - ramp;
            col_r = 8'd1;
        end
        if (!lit) begin
            col_r = '0;
            col_g = '0;
            col_b = '0;
        end
    end

    // Output register: load on emit, drop valid once transferred
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_idx_reg  <= idx_reg;
            out_r_reg    <= col_r;
            out_g_reg    <= col_g;
            out_b_reg    <= col_b;
            out_last_reg <= (idx_reg == '0);
        end
    end

    assign status.idx_zero = (idx_reg == '0);
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign led_index = out_idx_reg;
    assign red       = out_r_reg;
    assign green     = out_g_reg;
    assign blue      = out_b_reg;
    assign last      = out_last_reg;

    // Never overwrite a result that has not been transferred
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while stalled");

    // Peak hold never raises the bar past the LED count
    a_bar_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update_bar |=> (bar_reg == $past(bar_reg)) || (bar_reg <= BAR_W'(LED_COUNT)))
        else $error("bar level rose beyond LED count");

    // The LED at index 0 closes the run
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (out_last_reg == ($past(idx_reg) == '0)))
        else $error("last flag does not match LED index 0");

    // State steps only right after the final LED was loaded
    a_finish_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (out_valid_reg && out_last_reg))
        else $error("wheel/decay step without a completed run");

endmodule

FILE: src/audio_level_led_bar_rainbow.sv
// LED bar level meter with peak hold, decay and scrolling rainbow colors.
//
// Input stream: one 10-bit audio sample per transfer on s_tdata[9:0].
// Output stream: LED_COUNT transfers per sample, LED index LED_COUNT-1
// down to 0; m_tdata carries index and color, m_tlast marks LED 0.
// Config port: cfg_we with cfg_index 0 wheel speed, 1 gain, 2 decay period.
// The user writes it only while no sample is in work; the block does not enforce this.
//
// Sequence: a taken sample passes through level scaling (product, divide
// by full scale, gain, peak compare), then its LED colors leave one by
// one through the single output register, and a final step moves the
// wheel and decay counter. A stalled receiver holds the output register
// and pauses the LED count. s_tready is high only between samples, so a
// new sample is not taken until the last one is through.
// Reset: bar level 30, wheel at 255, decay count 0, speed 3, gain 4,
// decay period 5; output stream empty.
`timescale 1ns / 1ps

module audio_level_led_bar_rainbow #(
    parameter int LED_COUNT = 60
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_we,
    input  logic [alb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [alb_pkg::CFG_DAT_W-1:0]       cfg_data,
    // sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [alb_pkg::S_TDATA_W-1:0]       s_tdata,  // [9:0] audio_sample
    // LED color stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [alb_pkg::M_TDATA_W-1:0]       m_tdata,  // [5:0] led_index, [13:6] red,
                                                          // [21:14] green, [29:22] blue
    output logic                                m_tlast
);
    import alb_pkg::*;

    alb_cmd_t            cmd;
    alb_status_t         status;
    logic [INDEX_W-1:0]  led_index;
    logic [COLOR_W-1:0]  red, green, blue;

    alb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    alb_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .audio_sample (s_tdata[SAMPLE_W-1:0]),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .led_index    (led_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last         (m_tlast)
    );

    // Pack fields from the lowest bit up, pad to whole bytes
    assign m_tdata = {2'b00, blue, green, red, led_index};

endmodule
